// ----- rtl/core/report_crc32_filler_assert.svh -----
`ifndef REPORT_CRC32_FILLER_ASSERT_SVH
`define REPORT_CRC32_FILLER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RCF_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("report_crc32_filler assertion failed");

// next-cycle implication, checked outside reset
`define RCF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("report_crc32_filler assertion failed");

`endif

// ----- rtl/core/rcf_pkg.sv -----
package rcf_pkg;

	localparam int POS_W = 7;

	localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFFFFFF;
	localparam logic [7:0]  PREFIX_RESET = 8'hA2;
	localparam logic [7:0]  REPORT_ID_RESET = 8'h00;

	typedef enum logic {
		CFG_REPORT_ID   = 1'b0,
		CFG_PREFIX_BYTE = 1'b1
	} cfg_index_t;

	// one byte of reflected crc-32, lsb first
	function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'h000000, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/report_crc32_filler.sv -----
// report_crc32_filler: passes a fixed-length report through one byte per
// transaction and replaces its last four bytes with the reflected crc-32
// (little-endian) of the seed bytes prefix_byte, report_id and report
// bytes 1 to REPORT_LEN-5.
// input channel: in_valid/in_ready with in_byte and start_of_report; a set
// start flag forces the byte to be byte 0 of a new report.
// output channel: out_valid/out_ready with out_byte, end_of_report and
// crc_value (the finished crc on the last byte, else zero).
// config: cfg_we/cfg_index/cfg_wdata, to be written by the user only while the
// block is idle, which the block itself does not enforce; the seed of both crc
// bytes is folded into a register at the write.
// throughput: one byte per cycle while the output is not stalled, set by the
// single crc byte update between the input register and the output register.
// reset: position back to byte 0, report_id 0, prefix_byte 0xA2, both
// stages empty.
// stall: a held output keeps its result; an empty input register still takes one
// more transaction, after which in_ready drops until the output drains.
module report_crc32_filler #(
	parameter int REPORT_LEN = 78
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        start_of_report,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        end_of_report,
	output logic [31:0] crc_value,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata
);

	localparam int PW = rcf_pkg::POS_W;
	localparam logic [PW-1:0] POS_LEN   = PW'(REPORT_LEN);
	localparam logic [PW-1:0] POS_LAST  = PW'(REPORT_LEN - 1);
	localparam logic [PW-1:0] POS_DATA  = PW'(REPORT_LEN - 5);
	localparam logic [PW-1:0] POS_CRC0  = PW'(REPORT_LEN - 4);

	logic [7:0]    report_id_q;
	logic [7:0]    prefix_byte_q;
	logic [31:0]   seed_q;
	logic [7:0]    report_id_d;
	logic [7:0]    prefix_byte_d;

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          start_s1;

	logic [PW-1:0] pos_q;
	logic [31:0]   crc_q;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          eor_q;
	logic [31:0]   crc_value_q;

	logic          move;
	logic [PW-1:0] pos;
	logic [31:0]   fin;
	logic [1:0]    sel;
	logic [PW-1:0] pos_next;
	logic [31:0]   crc_next;
	logic [7:0]    obyte;
	logic          eor;

	assign move     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || move;

	always_comb begin
		report_id_d   = report_id_q;
		prefix_byte_d = prefix_byte_q;
		case (rcf_pkg::cfg_index_t'(cfg_index))
			rcf_pkg::CFG_REPORT_ID:   report_id_d   = cfg_wdata;
			rcf_pkg::CFG_PREFIX_BYTE: prefix_byte_d = cfg_wdata;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_id_q   <= rcf_pkg::REPORT_ID_RESET;
			prefix_byte_q <= rcf_pkg::PREFIX_RESET;
			seed_q        <= rcf_pkg::crc_feed(
				rcf_pkg::crc_feed(rcf_pkg::CRC_ALL_ONES, rcf_pkg::PREFIX_RESET),
				rcf_pkg::REPORT_ID_RESET);
		end else if (cfg_we) begin
			report_id_q   <= report_id_d;
			prefix_byte_q <= prefix_byte_d;
			seed_q        <= rcf_pkg::crc_feed(
				rcf_pkg::crc_feed(rcf_pkg::CRC_ALL_ONES, prefix_byte_d), report_id_d);
		end
	end

	// position and crc update for the byte in the input register
	always_comb begin
		if (start_s1 || pos_q >= POS_LEN) begin
			pos = '0;
		end else begin
			pos = pos_q;
		end
		fin      = ~crc_q;
		sel      = 2'(pos - POS_CRC0);
		obyte    = byte_s1;
		eor      = 1'b0;
		crc_next = crc_q;
		if (pos == '0) begin
			crc_next = seed_q;
		end else if (pos <= POS_DATA) begin
			crc_next = rcf_pkg::crc_feed(crc_q, byte_s1);
		end else begin
			obyte = fin[8*sel +: 8];
			eor   = (pos == POS_LAST);
		end
		if (pos >= POS_LAST) begin
			pos_next = '0;
			crc_next = rcf_pkg::CRC_ALL_ONES;
		end else begin
			pos_next = pos + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= in_byte;
			start_s1 <= start_of_report;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= rcf_pkg::CRC_ALL_ONES;
		end else if (move) begin
			pos_q <= pos_next;
			crc_q <= crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_byte_q  <= obyte;
			eor_q       <= eor;
			crc_value_q <= eor ? fin : 32'h00000000;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign end_of_report = eor_q;
	assign crc_value     = crc_value_q;

`include "report_crc32_filler_assert.svh"

	`RCF_ASSERT_IMPL(a_pos_in_range, 1'b1, pos_q < POS_LEN)
	`RCF_ASSERT_IMPL(a_last_byte_is_crc_msb, out_valid_q && eor_q, out_byte_q == crc_value_q[31:24])
	`RCF_ASSERT_IMPL(a_crc_zero_midreport, out_valid_q && !eor_q, crc_value_q == 32'h00000000)
	`RCF_ASSERT_NEXT(a_start_restarts, move && start_s1, pos_q == ((REPORT_LEN > 1) ? PW'(1) : PW'(0)))

endmodule

// ----- dv/report_crc32_filler_checker.sv -----
`timescale 1ns / 100ps

module report_crc32_filler_checker #(
	parameter int REPORT_LEN = 78
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        start_of_report,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_byte,
	input  logic        end_of_report,
	input  logic [31:0] crc_value,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	output int          err_count,
	output int          pending
);

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic [31:0] crc;
	} filled_byte_t;

	filled_byte_t filled_q[$];

	logic [7:0]  id_reg;
	logic [7:0]  prefix_reg;
	logic [6:0]  pos_reg;
	logic [31:0] crc_reg;
	int          errors;

	assign err_count = errors;
	assign pending   = filled_q.size();

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] r;
		r = crc ^ {24'd0, b};
		repeat (8) begin
			if (r[0]) begin
				r = {1'b0, r[31:1]} ^ rcf_pkg::CRC_POLY;
			end else begin
				r = {1'b0, r[31:1]};
			end
		end
		return r;
	endfunction

	task automatic fill_byte(input logic [7:0] data, input logic sof);
		int           p;
		int           sel;
		logic [31:0]  fin;
		filled_byte_t e;
		p = sof ? 0 : int'(pos_reg);
		if (p >= REPORT_LEN) begin
			p = 0;
		end
		e.data = data;
		e.last = 1'b0;
		e.crc  = 32'd0;
		if (p == 0) begin
			crc_reg = crc32_byte(crc32_byte(rcf_pkg::CRC_ALL_ONES, prefix_reg), id_reg);
		end else if (p <= REPORT_LEN - 5) begin
			crc_reg = crc32_byte(crc_reg, data);
		end else begin
			fin = crc_reg ^ rcf_pkg::CRC_ALL_ONES;
			sel = (p - (REPORT_LEN - 4)) & 3;
			e.data = fin[8*sel +: 8];
			if (p == REPORT_LEN - 1) begin
				e.last = 1'b1;
				e.crc  = fin;
			end
		end
		if (p >= REPORT_LEN - 1) begin
			pos_reg = '0;
			crc_reg = rcf_pkg::CRC_ALL_ONES;
		end else begin
			pos_reg = 7'(p + 1);
		end
		filled_q.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		filled_byte_t got;
		if (!arst_n) begin
			id_reg     = rcf_pkg::REPORT_ID_RESET;
			prefix_reg = rcf_pkg::PREFIX_RESET;
			pos_reg    = '0;
			crc_reg    = rcf_pkg::CRC_ALL_ONES;
			errors     = 0;
			filled_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == rcf_pkg::CFG_REPORT_ID) begin
					id_reg = cfg_wdata;
				end else begin
					prefix_reg = cfg_wdata;
				end
			end
			if (out_valid && out_ready) begin
				if (filled_q.size() == 0) begin
					$error("unexpected output transaction: out_byte %0h", out_byte);
					errors++;
				end else begin
					got = filled_q.pop_front();
					if (out_byte !== got.data) begin
						$error("out_byte: expected %0h, actual %0h", got.data, out_byte);
						errors++;
					end
					if (end_of_report !== got.last) begin
						$error("end_of_report: expected %0h, actual %0h", got.last,
							end_of_report);
						errors++;
					end
					if (crc_value !== got.crc) begin
						$error("crc_value: expected %0h, actual %0h", got.crc, crc_value);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				fill_byte(in_byte, start_of_report);
			end
		end
	end

endmodule

// ----- dv/tb_report_crc32_filler.sv -----
`timescale 1ns / 100ps

module tb_report_crc32_filler;

	localparam int REPORT_LEN  = 78;
	localparam int PHASE_BYTES = 180;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  in_byte;
	logic        start_of_report;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        end_of_report;
	logic [31:0] crc_value;
	logic        cfg_we;
	logic        cfg_index;
	logic [7:0]  cfg_wdata;

	int err_count;
	int pending;
	int cycles;
	int burst_left;
	int rdy_left;
	int stall_left;
	int phase;
	int phase_bytes;
	int kind;
	int len;
	int k;
	logic [7:0] rid;
	logic [7:0] pfx;

	report_crc32_filler #(
		.REPORT_LEN(REPORT_LEN)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.start_of_report(start_of_report),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.end_of_report(end_of_report),
		.crc_value(crc_value),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	report_crc32_filler_checker #(
		.REPORT_LEN(REPORT_LEN)
	) crc_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.start_of_report(start_of_report),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.end_of_report(end_of_report),
		.crc_value(crc_value),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.err_count(err_count),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver stall pattern
	initial begin
		out_ready  = 1'b0;
		rdy_left   = 0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rdy_left > 0) begin
				out_ready = 1'b1;
				rdy_left--;
			end else if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				rdy_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
					: $urandom_range(1, 20);
				stall_left = $urandom_range(1, 6);
			end
		end
	end

	// one input transaction, sender may idle between bursts
	task automatic send_byte(input logic [7:0] data, input logic sof);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		in_valid        = 1'b1;
		in_byte         = data;
		start_of_report = sof;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
		phase_bytes++;
	endtask

	task automatic drain_output();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input rcf_pkg::cfg_index_t idx, input logic [7:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		in_byte         = 8'h00;
		start_of_report = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = rcf_pkg::CFG_REPORT_ID;
		cfg_wdata       = 8'h00;
		burst_left      = 0;
		phase_bytes     = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset seeds, byte extremes, restarts mid report and back to back
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b1);
		send_byte(8'hFF, 1'b0);

		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					rid = 8'h00;
					pfx = 8'h00;
				end
				1: begin
					rid = 8'hFF;
					pfx = 8'hFF;
				end
				2: begin
					rid = 8'h00;
					pfx = 8'hFF;
				end
				3: begin
					rid = 8'hFF;
					pfx = 8'h00;
				end
				default: begin
					rid = 8'($urandom_range(0, 255));
					pfx = 8'($urandom_range(0, 255));
				end
			endcase
			drain_output();
			if ($urandom_range(0, 1) == 0) begin
				write_reg(rcf_pkg::CFG_REPORT_ID, rid);
				write_reg(rcf_pkg::CFG_PREFIX_BYTE, pfx);
			end else begin
				write_reg(rcf_pkg::CFG_PREFIX_BYTE, pfx);
				write_reg(rcf_pkg::CFG_REPORT_ID, rid);
			end
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				kind = $urandom_range(0, 9);
				if (kind <= 6) begin
					// well-formed report with start flag
					for (k = 0; k < REPORT_LEN; k++) begin
						send_byte(8'($urandom_range(0, 255)), k == 0);
					end
				end else if (kind == 7) begin
					// report relying on the position wrap
					for (k = 0; k < REPORT_LEN; k++) begin
						send_byte(8'($urandom_range(0, 255)), 1'b0);
					end
				end else if (kind == 8) begin
					// truncated report
					len = $urandom_range(1, REPORT_LEN - 1);
					for (k = 0; k < len; k++) begin
						send_byte(8'($urandom_range(0, 255)), k == 0);
					end
				end else begin
					// noise with random start flags
					len = $urandom_range(1, 20);
					for (k = 0; k < len; k++) begin
						send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
					end
				end
			end
		end

		drain_output();
		repeat (10) @(negedge clk);
		if (err_count == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
